// File: hw/rtl/pss_pkg.sv
`timescale 1ns / 1ps
// Shared types and constants for the probe-to-stage sphere transform.
// No dependencies.
package pss_pkg;

  localparam int SQ_STEPS = 32;   // radicand is below 2^62: two bits per step
  localparam int SQ_W     = 63;   // remainder / root working width
  localparam int ACC_W    = 40;   // wide signed sums before saturation

  typedef enum logic [2:0] {
    REG_X_CENTER      = 3'd0,
    REG_Y_CENTER      = 3'd1,
    REG_FOCUS_NOMINAL = 3'd2,
    REG_FOCUS_TRIM    = 3'd3,
    REG_PICKOFF_DX    = 3'd4,
    REG_PICKOFF_DY    = 3'd5,
    REG_RADIUS        = 3'd6,
    REG_AUTO_FOCUS    = 3'd7
  } reg_idx_t;

  typedef struct packed {
    logic               op;
    logic               auto_f;
    logic               beyond;
    logic signed [31:0] ix;
    logic signed [31:0] iy;
    logic signed [31:0] fin;
  } side_t;

  function automatic logic [31:0] sat32(input logic signed [ACC_W-1:0] v);
    if (v > ACC_W'(64'sd2147483647)) begin
      return 32'h7fff_ffff;
    end else if (v < -ACC_W'(64'sd2147483648)) begin
      return 32'h8000_0000;
    end else begin
      return v[31:0];
    end
  endfunction

endpackage

// File: hw/rtl/probe_to_stage_sphere_transform_top.sv
`timescale 1ns / 1ps
// Probe-to-stage sphere transform: fully pipelined, one request per cycle while
// the pipe advances (it stalls when the output register is full and not taken).
// The pipe is a 32-stage pipelined square root (two radicand bits per stage)
// plus abs, multiply, subtract, round and output-sum stages.
// The whole pipe advances when the output register is empty or taken.
// rst_n (synchronous) clears valid bits and loads register defaults.
// Depends on pss_pkg.
module probe_to_stage_sphere_transform_top (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_tvalid,
  output logic         in_tready,
  input  logic [95:0]  in_tdata,    // [31:0] in_x, [63:32] in_y, [95:64] focus_in
  input  logic [0:0]   in_tuser,    // [0] operation
  output logic         out_tvalid,
  input  logic         out_tready,
  output logic [95:0]  out_tdata,   // [31:0] out_x, [63:32] out_y, [95:64] out_focus
  output logic [0:0]   out_tuser,   // [0] out_of_range
  input  logic         cfg_valid,
  output logic         cfg_ready,
  input  logic [2:0]   cfg_index,
  input  logic [31:0]  cfg_data
);

  localparam int NS = pss_pkg::SQ_STEPS;
  localparam int W  = pss_pkg::SQ_W;
  localparam int AW = pss_pkg::ACC_W;

  // configuration registers
  logic signed [31:0] xc_r, yc_r, fnom_r, ftrim_r, pdx_r, pdy_r;
  logic        [30:0] rad_r;
  logic               auto_r;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      xc_r <= '0; yc_r <= '0; fnom_r <= '0; ftrim_r <= '0;
      pdx_r <= '0; pdy_r <= '0; rad_r <= '0; auto_r <= 1'b1;
    end else if (cfg_valid) begin
      unique case (pss_pkg::reg_idx_t'(cfg_index))
        pss_pkg::REG_X_CENTER:      xc_r    <= cfg_data;
        pss_pkg::REG_Y_CENTER:      yc_r    <= cfg_data;
        pss_pkg::REG_FOCUS_NOMINAL: fnom_r  <= cfg_data;
        pss_pkg::REG_FOCUS_TRIM:    ftrim_r <= cfg_data;
        pss_pkg::REG_PICKOFF_DX:    pdx_r   <= cfg_data;
        pss_pkg::REG_PICKOFF_DY:    pdy_r   <= cfg_data;
        pss_pkg::REG_RADIUS:        rad_r   <= cfg_data[30:0];
        pss_pkg::REG_AUTO_FOCUS:    auto_r  <= cfg_data[0];
        default: ;
      endcase
    end
  end

  // global advance: pipe moves when the output slot is free or being taken
  logic en;
  assign en        = !out_tvalid || out_tready;
  assign in_tready = en;

  // ---- stage 1: offset position and absolute values
  logic signed [32:0] dx, dy;
  logic        [32:0] ax_nxt, ay_nxt;
  logic        [32:0] ax_r, ay_r;
  logic               v1_r;
  pss_pkg::side_t     s1_r, s1_nxt;

  always_comb begin
    dx = 33'(signed'(in_tdata[31:0])) + 33'(pdx_r);
    dy = 33'(signed'(in_tdata[63:32])) + 33'(pdy_r);
    ax_nxt = dx[32] ? 33'(-dx) : 33'(dx);
    ay_nxt = dy[32] ? 33'(-dy) : 33'(dy);
    s1_nxt.op     = in_tuser[0];
    s1_nxt.auto_f = auto_r;
    s1_nxt.beyond = 1'b0;
    s1_nxt.ix     = in_tdata[31:0];
    s1_nxt.iy     = in_tdata[63:32];
    s1_nxt.fin    = in_tdata[95:64];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) v1_r <= 1'b0;
    else if (en) v1_r <= in_tvalid;
  end
  always_ff @(posedge clk) begin
    if (en) begin
      ax_r <= ax_nxt; ay_r <= ay_nxt; s1_r <= s1_nxt;
    end
  end

  // ---- stage 2: squares, box check against r
  logic [61:0]    ax2_r, ay2_r, r2_r;
  logic           v2_r;
  pss_pkg::side_t s2_r, s2_nxt;

  always_comb begin
    s2_nxt        = s1_r;
    s2_nxt.beyond = (ax_r > 33'(rad_r)) || (ay_r > 33'(rad_r));
  end

  always_ff @(posedge clk) begin
    if (!rst_n) v2_r <= 1'b0;
    else if (en) v2_r <= v1_r;
  end
  always_ff @(posedge clk) begin
    if (en) begin
      ax2_r <= ax_r[30:0] * ax_r[30:0];
      ay2_r <= ay_r[30:0] * ay_r[30:0];
      r2_r  <= rad_r * rad_r;
      s2_r  <= s2_nxt;
    end
  end

  // ---- stage 3: radicand r^2 - d^2
  logic [62:0] d2;
  assign d2 = 63'(ax2_r) + 63'(ay2_r);

  logic [W-1:0]   rem_r [0:NS];
  logic [W-1:0]   res_r [0:NS];
  logic           vq_r  [0:NS];
  pss_pkg::side_t sq_r  [0:NS];
  pss_pkg::side_t sq0_nxt;

  always_comb begin
    sq0_nxt        = s2_r;
    sq0_nxt.beyond = s2_r.beyond || (63'(r2_r) < d2);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) vq_r[0] <= 1'b0;
    else if (en) vq_r[0] <= v2_r;
  end
  always_ff @(posedge clk) begin
    if (en) begin
      rem_r[0] <= 63'(r2_r) - d2;
      res_r[0] <= '0;
      sq_r[0]  <= sq0_nxt;
    end
  end

  // ---- stages 4..35: restoring square root, one result bit per stage
  for (genvar k = 0; k < NS; k++) begin : g_sq
    localparam logic [W:0] BIT = (W+1)'(1) << (62 - 2*k);
    logic [W:0] trial;
    assign trial = {1'b0, res_r[k]} + BIT;

    always_ff @(posedge clk) begin
      if (!rst_n) vq_r[k+1] <= 1'b0;
      else if (en) vq_r[k+1] <= vq_r[k];
    end
    always_ff @(posedge clk) begin
      if (en) begin
        sq_r[k+1] <= sq_r[k];
        if ({1'b0, rem_r[k]} >= trial) begin
          rem_r[k+1] <= W'({1'b0, rem_r[k]} - trial);
          res_r[k+1] <= W'((res_r[k] >> 1) + BIT[W-1:0]);
        end else begin
          rem_r[k+1] <= rem_r[k];
          res_r[k+1] <= res_r[k] >> 1;
        end
      end
    end
  end

  // ---- stage 36: round to nearest, form sag
  logic [31:0]          root;
  logic signed [AW-1:0] sag_nxt, sag_r;
  logic                 flag_nxt, flag_r, v36_r;
  pss_pkg::side_t       s36_r;

  always_comb begin
    root = res_r[NS][31:0] + ((rem_r[NS] > res_r[NS]) ? 32'd1 : 32'd0);
    flag_nxt = 1'b0;
    if (sq_r[NS].auto_f) begin
      if (sq_r[NS].beyond) begin
        sag_nxt  = AW'(rad_r);
        flag_nxt = !sq_r[NS].op;
      end else begin
        sag_nxt = AW'(rad_r) - AW'(root);
      end
    end else begin
      sag_nxt = AW'(sq_r[NS].fin) - AW'(fnom_r) - AW'(ftrim_r);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) v36_r <= 1'b0;
    else if (en) v36_r <= vq_r[NS];
  end
  always_ff @(posedge clk) begin
    if (en) begin
      sag_r <= sag_nxt; flag_r <= flag_nxt; s36_r <= sq_r[NS];
    end
  end

  // ---- stage 37: output sums and saturation (output register)
  logic signed [AW-1:0] ox, oy, of;
  logic [95:0]          tdata_nxt;
  logic                 oor_nxt;

  always_comb begin
    if (!s36_r.op) begin
      ox = AW'(s36_r.ix) + AW'(xc_r);
      oy = AW'(s36_r.iy) + AW'(yc_r) - sag_r - AW'(ftrim_r);
      of = AW'(fnom_r) + sag_r + AW'(ftrim_r);
      oor_nxt = flag_r;
    end else begin
      // inverse: f + trim reduces to focus_in - nominal
      ox = AW'(s36_r.ix) - AW'(xc_r);
      oy = AW'(s36_r.iy) - AW'(yc_r) + AW'(s36_r.fin) - AW'(fnom_r);
      of = '0;
      oor_nxt = 1'b0;
    end
    tdata_nxt = {pss_pkg::sat32(of), pss_pkg::sat32(oy), pss_pkg::sat32(ox)};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) out_tvalid <= 1'b0;
    else if (en) out_tvalid <= v36_r;
  end
  always_ff @(posedge clk) begin
    if (en) begin
      out_tdata    <= tdata_nxt;
      out_tuser[0] <= oor_nxt;
    end
  end

endmodule
